@@ src/scsi_dma_channel_registers_macros.svh @@
// Assertion macros shared by the DMA channel register block.
// Depends on nothing; expects clk and rst_n in the scope of each use.
`ifndef SCSI_DMA_CHANNEL_REGISTERS_MACROS_SVH
`define SCSI_DMA_CHANNEL_REGISTERS_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SDC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdc assertion failed: same-cycle check");

// Check that the consequent holds in the cycle after the antecedent.
`define SDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdc assertion failed: next-cycle check");

`endif

@@ src/sdc_pkg.sv @@
// Types, register indexes and status bit constants for the DMA channel block.
// Depends on nothing.
`timescale 1ns / 1ps

package sdc_pkg;

    typedef enum logic [1:0] {
        CMD_REG_WRITE = 2'd0,
        CMD_REG_READ  = 2'd1,
        CMD_CORE_IRQ  = 2'd2,
        CMD_TRANSFER  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_IDLE  = 2'd0,
        OP_BLAST = 2'd1,
        OP_ABORT = 2'd2,
        OP_START = 2'd3
    } dma_op_t;

    typedef enum logic [1:0] {
        EVT_NONE    = 2'd0,
        EVT_DISABLE = 2'd1,
        EVT_ENABLE  = 2'd2
    } dma_event_t;

    localparam logic [2:0] R_CMD   = 3'd0;
    localparam logic [2:0] R_STC   = 3'd1;
    localparam logic [2:0] R_SPA   = 3'd2;
    localparam logic [2:0] R_WBC   = 3'd3;
    localparam logic [2:0] R_WAC   = 3'd4;
    localparam logic [2:0] R_STAT  = 3'd5;
    localparam logic [2:0] R_SMDLA = 3'd6;
    localparam logic [2:0] R_WMAC  = 3'd7;

    localparam int NUM_REGS = 8;

    localparam logic [31:0] CMD_OP_MASK   = 32'h0000_0003;
    localparam logic [31:0] CMD_DONE_EN   = 32'h0000_0040;
    localparam logic [31:0] CMD_TO_MEMORY = 32'h0000_0080;

    localparam logic [31:0] ST_PWDN  = 32'h0000_0001;
    localparam logic [31:0] ST_ERROR = 32'h0000_0002;
    localparam logic [31:0] ST_ABORT = 32'h0000_0004;
    localparam logic [31:0] ST_DONE  = 32'h0000_0008;
    localparam logic [31:0] ST_SCSI  = 32'h0000_0010;
    localparam logic [31:0] ST_BLAST = 32'h0000_0020;

    localparam logic [31:0] ST_CLEARABLE = ST_ERROR | ST_ABORT | ST_DONE;
    localparam logic [31:0] ST_START_CLR = ST_BLAST | ST_SCSI | ST_DONE | ST_ABORT
                                         | ST_ERROR | ST_PWDN;

    localparam logic [31:0] WAC_RESET  = 32'hffff_ffff;
    localparam logic [31:0] WMAC_RESET = 32'hffff_fffd;

    typedef logic [NUM_REGS-1:0][31:0] regs_t;

    // Register file after reset, highest index first.
    localparam regs_t REGS_RESET = {WMAC_RESET, 32'd0, 32'd0, WAC_RESET,
                                    32'd0, 32'd0, 32'd0, 32'd0};

    typedef struct packed {
        cmd_t        command;
        logic [2:0]  reg_index;
        logic [31:0] write_data;
        logic        irq_level;
        logic [15:0] transfer_len;
        logic        transfer_to_memory;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
        dma_event_t  dma_enable_event;
        logic        cancel_request;
        logic        transfer_accepted;
        logic [31:0] transfer_address;
        logic [15:0] granted_len;
    } result_t;

    function automatic logic line_level(input regs_t r);
        line_level = ((r[R_STAT] & ST_SCSI) != 32'd0)
                   || (((r[R_CMD] & CMD_DONE_EN) != 32'd0) && ((r[R_STAT] & ST_DONE) != 32'd0));
    endfunction

endpackage

@@ src/sdc_regfile.sv @@
// Eight 32-bit DMA registers with their reset values.
// Depends on sdc_pkg.
`timescale 1ns / 1ps

module sdc_regfile (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  sdc_pkg::regs_t regs_next,
    output sdc_pkg::regs_t regs
);
    import sdc_pkg::*;

    regs_t regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= REGS_RESET;
        end
        else if (we)
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

@@ src/sdc_exec.sv @@
// Combinational step: one item against the register file gives the next
// register contents and the result item. Depends on sdc_pkg.
`timescale 1ns / 1ps

module sdc_exec (
    input  sdc_pkg::item_t   item,
    input  sdc_pkg::regs_t   regs,
    input  logic             clear_by_write,
    output sdc_pkg::regs_t   regs_next,
    output sdc_pkg::result_t result
);
    import sdc_pkg::*;

    regs_t       nxt;
    result_t     res;
    logic [15:0] grant;
    logic        want_to_mem;

    always_comb
    begin
        nxt         = regs;
        res         = '0;
        want_to_mem = (regs[R_CMD] & CMD_TO_MEMORY) != 32'd0;
        grant       = (regs[R_WBC] < {16'd0, item.transfer_len})
                    ? regs[R_WBC][15:0] : item.transfer_len;

        unique case (item.command)
            CMD_REG_WRITE:
            begin
                unique case (item.reg_index)
                    R_CMD:
                    begin
                        nxt[R_CMD] = item.write_data;
                        unique case (dma_op_t'(item.write_data[1:0]))
                            OP_IDLE:  res.dma_enable_event = EVT_DISABLE;
                            OP_BLAST: nxt[R_STAT] = regs[R_STAT] | ST_BLAST;
                            OP_ABORT: res.cancel_request = 1'b1;
                            OP_START:
                            begin
                                nxt[R_WBC]  = regs[R_STC];
                                nxt[R_WAC]  = regs[R_SPA];
                                nxt[R_WMAC] = regs[R_SMDLA];
                                nxt[R_STAT] = regs[R_STAT] & ~ST_START_CLR;
                                res.dma_enable_event = EVT_ENABLE;
                            end
                        endcase
                    end
                    R_STC, R_SPA, R_SMDLA:
                        nxt[item.reg_index] = item.write_data;
                    R_STAT:
                        if (clear_by_write)
                            nxt[R_STAT] = regs[R_STAT] & ~(item.write_data & ST_CLEARABLE);
                    default:
                        ;  // working registers are read-only
                endcase
            end
            CMD_REG_READ:
            begin
                res.read_data = regs[item.reg_index];
                if (item.reg_index == R_STAT && !clear_by_write)
                    nxt[R_STAT] = regs[R_STAT] & ~ST_CLEARABLE;
            end
            CMD_CORE_IRQ:
            begin
                if (item.irq_level)
                begin
                    nxt[R_STAT] = regs[R_STAT] | ST_SCSI;
                    if ((regs[R_CMD] & CMD_OP_MASK) == CMD_OP_MASK && regs[R_WBC] == 32'd0)
                        nxt[R_STAT] = regs[R_STAT] | ST_SCSI | ST_DONE;
                end
                else
                begin
                    nxt[R_STAT] = regs[R_STAT] & ~ST_SCSI;
                end
            end
            CMD_TRANSFER:
            begin
                if (want_to_mem == item.transfer_to_memory)
                begin
                    res.transfer_accepted = 1'b1;
                    res.transfer_address  = regs[R_WAC];
                    res.granted_len       = grant;
                    nxt[R_WBC] = regs[R_WBC] - {16'd0, grant};
                    nxt[R_WAC] = regs[R_WAC] + {16'd0, grant};
                end
            end
        endcase

        res.irq = line_level(nxt);
    end

    assign regs_next = nxt;
    assign result    = res;

endmodule

@@ src/scsi_dma_channel_registers.sv @@
// SCSI host DMA channel registers: an accepted item is held in the input register, and its
// result goes to the result register when that register is free or draining. One item per
// cycle while the sink keeps taking results; each item does one read-modify-write of the
// eight-register file between the input register and the result register.
// Reset (rst_n, async, active low): registers zero, working address ffffffff,
// working list address fffffffd, clear-on-read status mode, both stages empty.
`timescale 1ns / 1ps

module scsi_dma_channel_registers (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: status_clear_by_write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // tuser: command[1:0]
    input  logic [1:0]  s_tuser,
    // tdata: reg_index[2:0], write_data[34:3], irq_level[35],
    //        transfer_len[51:36], transfer_to_memory[52], zero pad[55:53]
    input  logic [55:0] s_tdata,
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: read_data[31:0], irq[32], dma_enable_event[34:33],
    //        cancel_request[35], transfer_accepted[36], transfer_address[68:37],
    //        granted_len[84:69], zero pad[87:85]
    output logic [87:0] m_tdata
);
    import sdc_pkg::*;

`include "scsi_dma_channel_registers_macros.svh"

    // Input stage: hold one accepted item until the execute step can retire it.
    item_t   in_item_reg;
    logic    in_valid_reg;
    // Result stage: hold the finished result until the sink takes it.
    result_t out_reg;
    logic    out_valid_reg;
    // Status clearing mode.
    logic    clear_by_write_reg;

    item_t   in_item;
    regs_t   regs;
    regs_t   regs_next;
    result_t result;
    logic    advance;
    logic    in_fire;

    // Unpack the stream payload into an item.
    assign in_item.command            = cmd_t'(s_tuser);
    assign in_item.reg_index          = s_tdata[2:0];
    assign in_item.write_data         = s_tdata[34:3];
    assign in_item.irq_level          = s_tdata[35];
    assign in_item.transfer_len       = s_tdata[51:36];
    assign in_item.transfer_to_memory = s_tdata[52];

    // Retire the held item whenever the result register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_by_write_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            clear_by_write_reg <= cfg_data[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_item_reg <= '0;
        end
        else if (in_fire)
        begin
            in_item_reg <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    // Register file updates together with the result register.
    sdc_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .we        (advance),
        .regs_next (regs_next),
        .regs      (regs)
    );

    sdc_exec u_exec (
        .item           (in_item_reg),
        .regs           (regs),
        .clear_by_write (clear_by_write_reg),
        .regs_next      (regs_next),
        .result         (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_reg.granted_len,
                       out_reg.transfer_address,
                       out_reg.transfer_accepted,
                       out_reg.cancel_request,
                       out_reg.dma_enable_event,
                       out_reg.irq,
                       out_reg.read_data};

    // A retired item always lands in the result register.
    `SDC_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_reg)
    // The shown interrupt level matches the registers it was computed from.
    `SDC_ASSERT_SAME(a_irq_matches_regs, out_valid_reg, out_reg.irq == line_level(regs))
    // A transfer never raises the working count.
    `SDC_ASSERT_NEXT(a_count_never_grows,
        advance && in_item_reg.command == CMD_TRANSFER,
        regs[R_WBC] <= $past(regs[R_WBC]))
    // Abort and enable/disable come from different command codes.
    `SDC_ASSERT_SAME(a_event_cancel_excl, out_valid_reg,
        !(out_reg.cancel_request && out_reg.dma_enable_event != EVT_NONE))

endmodule

@@ test/dma_channel_scoreboard_pkg.sv @@
// Scoreboard for the SCSI DMA channel register block: predicts each result item.
// Depends on sdc_pkg for the item and result types, register indexes and status bits.
`timescale 1ns / 1ps

package dma_channel_scoreboard_pkg;

    import sdc_pkg::*;

    class dma_channel_scoreboard;

        logic [31:0] shadow [NUM_REGS];
        bit          clear_by_write;
        result_t     expected_q[$];
        int unsigned mismatches;

        function new();
            foreach (shadow[i])
                shadow[i] = 32'd0;
            shadow[R_WAC]  = WAC_RESET;
            shadow[R_WMAC] = WMAC_RESET;
            clear_by_write = 1'b0;
            mismatches     = 0;
        endfunction

        function void set_clear_mode(bit mode);
            clear_by_write = mode;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Apply one accepted item to the register copy and queue its result.
        function void note_item(item_t it);
            result_t     res;
            logic [31:0] op_bits;
            logic [15:0] grant;
            bit          want_to_mem;
            res = '0;
            case (it.command)
                CMD_REG_WRITE:
                begin
                    case (it.reg_index)
                        R_CMD:
                        begin
                            shadow[R_CMD] = it.write_data;
                            op_bits = it.write_data & CMD_OP_MASK;
                            case (dma_op_t'(op_bits[1:0]))
                                OP_IDLE:  res.dma_enable_event = EVT_DISABLE;
                                OP_BLAST: shadow[R_STAT] |= ST_BLAST;
                                OP_ABORT: res.cancel_request = 1'b1;
                                default:
                                begin
                                    shadow[R_WBC]   = shadow[R_STC];
                                    shadow[R_WAC]   = shadow[R_SPA];
                                    shadow[R_WMAC]  = shadow[R_SMDLA];
                                    shadow[R_STAT] &= ~ST_START_CLR;
                                    res.dma_enable_event = EVT_ENABLE;
                                end
                            endcase
                        end
                        R_STC, R_SPA, R_SMDLA:
                            shadow[it.reg_index] = it.write_data;
                        R_STAT:
                            if (clear_by_write)
                                shadow[R_STAT] &= ~(it.write_data & ST_CLEARABLE);
                        default: ;
                    endcase
                end
                CMD_REG_READ:
                begin
                    res.read_data = shadow[it.reg_index];
                    if (it.reg_index == R_STAT && !clear_by_write)
                        shadow[R_STAT] &= ~ST_CLEARABLE;
                end
                CMD_CORE_IRQ:
                begin
                    if (it.irq_level)
                    begin
                        shadow[R_STAT] |= ST_SCSI;
                        op_bits = shadow[R_CMD] & CMD_OP_MASK;
                        if (dma_op_t'(op_bits[1:0]) == OP_START && shadow[R_WBC] == 32'd0)
                            shadow[R_STAT] |= ST_DONE;
                    end
                    else
                        shadow[R_STAT] &= ~ST_SCSI;
                end
                default:
                begin
                    want_to_mem = (shadow[R_CMD] & CMD_TO_MEMORY) != 32'd0;
                    if (want_to_mem == it.transfer_to_memory)
                    begin
                        grant = (shadow[R_WBC] < {16'd0, it.transfer_len})
                              ? shadow[R_WBC][15:0] : it.transfer_len;
                        res.transfer_accepted = 1'b1;
                        res.transfer_address  = shadow[R_WAC];
                        res.granted_len       = grant;
                        shadow[R_WBC] -= {16'd0, grant};
                        shadow[R_WAC] += {16'd0, grant};
                    end
                end
            endcase
            res.irq = ((shadow[R_STAT] & ST_SCSI) != 32'd0)
                   || (((shadow[R_CMD] & CMD_DONE_EN) != 32'd0)
                       && ((shadow[R_STAT] & ST_DONE) != 32'd0));
            expected_q.push_back(res);
        endfunction

        function void compare_field(string field_name, logic [31:0] want_v, logic [31:0] got_v);
            if (want_v !== got_v)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field_name, want_v, got_v);
            end
        endfunction

        // Compare one result item with the oldest prediction.
        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("irq", 32'(want.irq), 32'(got.irq));
            compare_field("dma_enable_event", 32'(want.dma_enable_event),
                          32'(got.dma_enable_event));
            compare_field("cancel_request", 32'(want.cancel_request), 32'(got.cancel_request));
            compare_field("transfer_accepted", 32'(want.transfer_accepted),
                          32'(got.transfer_accepted));
            compare_field("transfer_address", want.transfer_address, got.transfer_address);
            compare_field("granted_len", 32'(want.granted_len), 32'(got.granted_len));
        endfunction

    endclass

endpackage

@@ test/tb_top.sv @@
// Top-level testbench for scsi_dma_channel_registers: drives stream items and checks results.
// Depends on sdc_pkg and dma_channel_scoreboard_pkg; needs nothing but the RTL.
`timescale 1ns / 1ps

module tb_top;

    import sdc_pkg::*;
    import dma_channel_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int ITEMS_PER_PASS = 670;
    localparam int SETTLE_CYCLES  = 10;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;   // command[1:0]
    logic [55:0] s_tdata;   // reg_index, write_data, irq_level, transfer_len,
                            // transfer_to_memory, zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;   // read_data, irq, dma_enable_event, cancel_request,
                            // transfer_accepted, transfer_address, granted_len, pad

    dma_channel_scoreboard sb;

    int unsigned items_sent;
    int unsigned cycle_count;
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;

    scsi_dma_channel_registers dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: end the run if the block stops making progress.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Receiver: drop tready at random per cycle according to the current pressure.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Unpack every accepted result item and hand it to the scoreboard.
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.read_data         = m_tdata[31:0];
            got.irq               = m_tdata[32];
            got.dma_enable_event  = dma_event_t'(m_tdata[34:33]);
            got.cancel_request    = m_tdata[35];
            got.transfer_accepted = m_tdata[36];
            got.transfer_address  = m_tdata[68:37];
            got.granted_len       = m_tdata[84:69];
            sb.check_result(got);
        end
    end

    // Fill every field with random content; callers override what matters.
    function automatic item_t random_item();
        item_t it;
        it.command            = cmd_t'($urandom_range(3));
        it.reg_index          = 3'($urandom_range(7));
        it.write_data         = $urandom;
        it.irq_level          = 1'($urandom_range(1));
        it.transfer_len       = 16'($urandom_range(65535));
        it.transfer_to_memory = 1'($urandom_range(1));
        return it;
    endfunction

    // Present one item at the falling edge, hold it until the block takes it,
    // note it in the scoreboard at the accepting edge, then drop tvalid.
    task automatic send_item(item_t it);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = it.command;
        s_tdata  = {3'b000, it.transfer_to_memory, it.transfer_len, it.irq_level,
                    it.write_data, it.reg_index};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(it);
        items_sent++;
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] data);
        item_t it;
        it            = random_item();
        it.command    = CMD_REG_WRITE;
        it.reg_index  = idx;
        it.write_data = data;
        send_item(it);
    endtask

    task automatic reg_read(logic [2:0] idx);
        item_t it;
        it           = random_item();
        it.command   = CMD_REG_READ;
        it.reg_index = idx;
        send_item(it);
    endtask

    task automatic core_irq(logic lvl);
        item_t it;
        it           = random_item();
        it.command   = CMD_CORE_IRQ;
        it.irq_level = lvl;
        send_item(it);
    endtask

    task automatic transfer(logic [15:0] len, logic to_mem);
        item_t it;
        it                    = random_item();
        it.command            = CMD_TRANSFER;
        it.transfer_len       = len;
        it.transfer_to_memory = to_mem;
        send_item(it);
    endtask

    // Build a command word with random upper bits and the given operation.
    function automatic logic [31:0] command_word(dma_op_t op);
        logic [31:0] w;
        w = $urandom;
        return (w & ~CMD_OP_MASK) | 32'(op);
    endfunction

    // Hold until every predicted result has come back.
    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Write the status clear mode; only called while the block is idle.
    task automatic set_clear_mode(bit mode);
        cfg_valid = 1'b1;
        cfg_data  = mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_clear_mode(mode);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly complete DMA sessions with random content, the rest single random items.
    task automatic random_pass(int unsigned n_items);
        int unsigned stop_at;
        logic [31:0] count;
        logic [31:0] cmd_w;
        logic [15:0] len;
        bit          dir;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < 70)
            begin
                // program start count: mostly small so that counts run out
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: count = $urandom_range(512);
                    5, 6, 7:       count = $urandom_range(65535);
                    default:       count = $urandom;
                endcase
                reg_write(R_STC, count);
                reg_write(R_SPA, $urandom);
                if ($urandom_range(1))
                    reg_write(R_SMDLA, $urandom);
                dir   = 1'($urandom_range(1));
                cmd_w = command_word(OP_START);
                if (dir)
                    cmd_w |= CMD_TO_MEMORY;
                else
                    cmd_w &= ~CMD_TO_MEMORY;
                reg_write(R_CMD, cmd_w);
                repeat ($urandom_range(1, 6))
                begin
                    len = ($urandom_range(9) < 6) ? 16'($urandom_range(256))
                                                  : 16'($urandom_range(65535));
                    transfer(len, ($urandom_range(99) < 85) ? dir : !dir);
                    if ($urandom_range(3) == 0)
                        reg_read(3'($urandom_range(7)));
                end
                if ($urandom_range(3) != 0)
                    core_irq(1'b1);
                if ($urandom_range(1))
                    reg_read(R_STAT);
                else
                    reg_write(R_STAT, $urandom);
                if ($urandom_range(1))
                    core_irq(1'b0);
                if ($urandom_range(2) == 0)
                    reg_write(R_CMD, command_word(dma_op_t'($urandom_range(3))));
            end
            else
                send_item(random_item());
        end
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        s_tvalid      = 1'b0;
        s_tuser       = CMD_REG_WRITE;
        s_tdata       = '0;
        items_sent    = 0;
        cycle_count   = 0;
        src_idle_pct  = 25;
        sink_idle_pct = 63;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part in read-clear mode: reset values, read-only registers,
        // address wrap, clipped grant, done on core interrupt, every command op.
        set_clear_mode(1'b0);
        reg_read(R_WAC);
        reg_read(R_WMAC);
        reg_write(R_WBC, 32'hffff_ffff);
        reg_write(R_WMAC, 32'h0000_0000);
        reg_write(R_STC, 32'h0000_0010);
        reg_write(R_SPA, 32'hffff_fff8);
        reg_write(R_SMDLA, 32'h1234_5678);
        reg_write(R_CMD, CMD_TO_MEMORY | CMD_DONE_EN | 32'(OP_START));
        transfer(16'hffff, 1'b1);
        transfer(16'h0040, 1'b0);
        core_irq(1'b1);
        reg_read(R_STAT);
        reg_write(R_STAT, 32'hffff_ffff);
        core_irq(1'b0);
        reg_write(R_CMD, 32'(OP_BLAST));
        reg_write(R_CMD, 32'(OP_ABORT));
        reg_write(R_CMD, 32'(OP_IDLE));
        transfer(16'h0000, 1'b0);
        wait_drained();

        // Directed part in write-one-to-clear mode.
        set_clear_mode(1'b1);
        reg_write(R_STC, 32'h0000_0000);
        reg_write(R_CMD, CMD_DONE_EN | 32'(OP_START));
        core_irq(1'b1);
        reg_write(R_STAT, ST_CLEARABLE);
        reg_read(R_STAT);
        core_irq(1'b0);
        reg_write(R_STAT, 32'hffff_ffff);
        reg_read(R_STAT);
        wait_drained();

        // Random passes: sender light / receiver heavy, then swapped, then no idling.
        random_pass(ITEMS_PER_PASS);
        wait_drained();
        set_clear_mode(1'b0);
        src_idle_pct  = 63;
        sink_idle_pct = 25;
        random_pass(ITEMS_PER_PASS);
        wait_drained();
        set_clear_mode(1'b1);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_pass(ITEMS_PER_PASS);
        s_tvalid = 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
